@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies a consequence on the following edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/smbrw_pkg.sv @@
package smbrw_pkg;

	localparam int CNT_W  = 16;
	localparam int REG_W  = 16;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [7:0]  CRC_POLY  = 8'h07;
	localparam logic [15:0] NACK_WORD = 16'hFFFF;

	typedef enum logic {
		REG_HALF_BIT,
		REG_ACK_TIMEOUT
	} reg_idx_t;

	typedef enum logic [4:0] {
		PH_IDLE, PH_PSTOP_A, PH_PSTOP_B, PH_PSTOP_C, PH_START_A, PH_START_B, PH_START_C,
		PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_HIGH, PH_RX_LOW, PH_RX_HIGH,
		PH_MACK_LOW, PH_MACK_HIGH, PH_STOP_A, PH_STOP_B, PH_STOP_C
	} phase_t;

	typedef enum logic [2:0] {
		BN_WADDR, BN_CMD, BN_RADDR, BN_LOW, BN_HIGH, BN_PEC
	} byte_num_t;

	typedef enum logic [1:0] {
		ST_OK, ST_WADDR_NACK, ST_CMD_NACK, ST_RADDR_NACK
	} status_t;

	// CRC-8, MSB first, over one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// a zero register counts as one
	function automatic logic [CNT_W-1:0] lim_of(input logic [REG_W-1:0] r);
		logic [CNT_W-1:0] v;
		v = CNT_W'(r);
		if (v == '0) begin
			v = CNT_W'(1);
		end
		return v;
	endfunction

endpackage

@@ design/smbrw_ifs.sv @@
interface smbrw_in_if;
	logic       valid;
	logic       ready;
	logic       start_request;
	logic [6:0] slave_address;
	logic [7:0] command_code;
	logic       sda_in;

	modport source (output valid, start_request, slave_address, command_code, sda_in,
		input ready);
	modport sink (input valid, start_request, slave_address, command_code, sda_in,
		output ready);
endinterface

interface smbrw_out_if;
	logic        valid;
	logic        ready;
	logic        scl_out;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic [15:0] read_word;
	logic        pec_ok;
	logic [1:0]  status_code;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, read_word, pec_ok,
		status_code, input ready);
	modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_word, pec_ok,
		status_code, output ready);
endinterface

@@ design/smbus_read_word_pec_master_unit.sv @@
// Pipeline: a tick beat accepted into the input register yields its result beat from
//   the result register (one input register, one result register).
// Throughput: one tick beat per cycle; the sequencer state advances once per beat,
//   and stalls only while the result register holds an untaken beat.
// Reset: arst_n clears the sequencer to idle, both registers to 100 and 1000,
//   and empties the input and result registers.
`include "assert_macros.svh"

module smbus_read_word_pec_master_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [smbrw_pkg::ADDR_W-1:0]           paddr,
	input  logic [smbrw_pkg::DATA_W-1:0]           pwdata,
	output logic [smbrw_pkg::DATA_W-1:0]           prdata,
	output logic                                   pready,
	smbrw_in_if.sink                               req,
	smbrw_out_if.source                            rsp
);

	// ---------------------------------------------------------------
	// Configuration registers: written on the APB access phase.
	// Register index is the word address bit.
	// ---------------------------------------------------------------
	logic [smbrw_pkg::REG_W-1:0] half_bit_q;
	logic [smbrw_pkg::REG_W-1:0] ack_to_q;
	smbrw_pkg::reg_idx_t         reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = smbrw_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= smbrw_pkg::REG_W'(100);
			ack_to_q   <= smbrw_pkg::REG_W'(1000);
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				smbrw_pkg::REG_HALF_BIT:    half_bit_q <= pwdata[smbrw_pkg::REG_W-1:0];
				smbrw_pkg::REG_ACK_TIMEOUT: ack_to_q   <= pwdata[smbrw_pkg::REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			smbrw_pkg::REG_HALF_BIT:    prdata = smbrw_pkg::DATA_W'(half_bit_q);
			smbrw_pkg::REG_ACK_TIMEOUT: prdata = smbrw_pkg::DATA_W'(ack_to_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Handshake: input register s1, result register s2.
	// Advance the sequencer whenever s1 holds a beat and s2 is free or
	// draining; take a new beat whenever s1 is empty or advancing.
	// ---------------------------------------------------------------
	logic       in_vld_s1;
	logic       start_s1;
	logic [6:0] addr_s1;
	logic [7:0] cmd_s1;
	logic       sda_s1;
	logic       out_vld_s2;
	logic       adv;

	assign adv       = in_vld_s1 && (!out_vld_s2 || rsp.ready);
	assign req.ready = !in_vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			in_vld_s1 <= 1'b1;
		end else if (adv) begin
			in_vld_s1 <= 1'b0;
		end
	end

	// payload only: no reset needed
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			start_s1 <= req.start_request;
			addr_s1  <= req.slave_address;
			cmd_s1   <= req.command_code;
			sda_s1   <= req.sda_in;
		end
	end

	// ---------------------------------------------------------------
	// Sequencer state
	// ---------------------------------------------------------------
	smbrw_pkg::phase_t           phase_q, phase_n;
	logic [3:0]                  bit_q, bit_n;
	smbrw_pkg::byte_num_t        bnum_q, bnum_n;
	smbrw_pkg::status_t          stat_q, stat_n;
	logic [7:0]                  shift_q, shift_n;
	logic [7:0]                  low_q, low_n;
	logic [7:0]                  high_q, high_n;
	logic [7:0]                  crc_q, crc_n;
	logic [6:0]                  haddr_q, haddr_n;
	logic [7:0]                  hcmd_q, hcmd_n;
	logic [smbrw_pkg::CNT_W-1:0] tick_q, tick_n;
	logic [smbrw_pkg::CNT_W-1:0] wait_q, wait_n;
	logic                        done_n;

	logic [smbrw_pkg::CNT_W-1:0] half_lim, ack_lim;
	logic [smbrw_pkg::CNT_W:0]   tick_inc, wait_inc;
	logic                        seg_last, ack_last;
	logic [7:0]                  crc_byte_sel, crc_upd;

	assign half_lim = smbrw_pkg::lim_of(half_bit_q);
	assign ack_lim  = smbrw_pkg::lim_of(ack_to_q);
	assign tick_inc = {1'b0, tick_q} + 1'b1;
	assign wait_inc = {1'b0, wait_q} + 1'b1;
	// last tick of a half period / setup segment
	assign seg_last = tick_inc >= {1'b0, half_lim};
	// last high sample tolerated while waiting for the slave ACK
	assign ack_last = wait_inc >= {1'b0, ack_lim};

	// One CRC unit: the address byte when a start finishes, the command
	// byte after the write-address ACK, otherwise the received byte.
	always_comb begin
		priority case (phase_q)
			smbrw_pkg::PH_START_C:  crc_byte_sel = {haddr_q, bnum_q != smbrw_pkg::BN_WADDR};
			smbrw_pkg::PH_ACK_HIGH: crc_byte_sel = hcmd_q;
			default:                crc_byte_sel = shift_q;
		endcase
	end
	assign crc_upd = smbrw_pkg::crc8_byte(crc_q, crc_byte_sel);

	// Next state
	always_comb begin
		phase_n = phase_q;
		bit_n   = bit_q;
		bnum_n  = bnum_q;
		stat_n  = stat_q;
		shift_n = shift_q;
		low_n   = low_q;
		high_n  = high_q;
		crc_n   = crc_q;
		haddr_n = haddr_q;
		hcmd_n  = hcmd_q;
		tick_n  = tick_q;
		wait_n  = wait_q;
		done_n  = 1'b0;

		if (adv) begin
			unique case (phase_q)
				smbrw_pkg::PH_IDLE: begin
					if (start_s1) begin
						haddr_n = addr_s1;
						hcmd_n  = cmd_s1;
						crc_n   = '0;
						stat_n  = smbrw_pkg::ST_OK;
						bnum_n  = smbrw_pkg::BN_WADDR;
						low_n   = '0;
						high_n  = '0;
						shift_n = '0;
						bit_n   = '0;
						tick_n  = '0;
						wait_n  = '0;
						phase_n = smbrw_pkg::PH_PSTOP_A;
					end
				end
				smbrw_pkg::PH_PSTOP_A, smbrw_pkg::PH_PSTOP_B, smbrw_pkg::PH_PSTOP_C,
				smbrw_pkg::PH_START_A, smbrw_pkg::PH_START_B,
				smbrw_pkg::PH_TX_LOW, smbrw_pkg::PH_ACK_LOW, smbrw_pkg::PH_RX_LOW,
				smbrw_pkg::PH_MACK_LOW, smbrw_pkg::PH_STOP_A, smbrw_pkg::PH_STOP_B: begin
					if (seg_last) begin
						tick_n  = '0;
						// these segments step to the next phase in order
						phase_n = smbrw_pkg::phase_t'(phase_q + 5'd1);
						if (phase_q == smbrw_pkg::PH_ACK_LOW) begin
							wait_n = '0;
						end
					end else begin
						tick_n = tick_inc[smbrw_pkg::CNT_W-1:0];
					end
				end
				smbrw_pkg::PH_START_C: begin
					if (seg_last) begin
						shift_n = crc_byte_sel;
						bit_n   = '0;
						crc_n   = crc_upd;
						tick_n  = '0;
						phase_n = smbrw_pkg::PH_TX_LOW;
					end else begin
						tick_n = tick_inc[smbrw_pkg::CNT_W-1:0];
					end
				end
				smbrw_pkg::PH_TX_HIGH: begin
					if (seg_last) begin
						tick_n  = '0;
						shift_n = {shift_q[6:0], 1'b0};
						if (bit_q == 4'd7) begin
							bit_n   = '0;
							wait_n  = '0;
							phase_n = smbrw_pkg::PH_ACK_LOW;
						end else begin
							bit_n   = bit_q + 4'd1;
							phase_n = smbrw_pkg::PH_TX_LOW;
						end
					end else begin
						tick_n = tick_inc[smbrw_pkg::CNT_W-1:0];
					end
				end
				smbrw_pkg::PH_ACK_HIGH: begin
					if (!sda_s1) begin
						tick_n = '0;
						priority case (bnum_q)
							smbrw_pkg::BN_WADDR: begin
								bnum_n  = smbrw_pkg::BN_CMD;
								shift_n = hcmd_q;
								bit_n   = '0;
								crc_n   = crc_upd;
								phase_n = smbrw_pkg::PH_TX_LOW;
							end
							smbrw_pkg::BN_CMD: begin
								bnum_n  = smbrw_pkg::BN_RADDR;
								phase_n = smbrw_pkg::PH_START_A;
							end
							default: begin
								bnum_n  = smbrw_pkg::BN_LOW;
								bit_n   = '0;
								shift_n = '0;
								phase_n = smbrw_pkg::PH_RX_LOW;
							end
						endcase
					end else if (ack_last) begin
						priority case (bnum_q)
							smbrw_pkg::BN_WADDR: stat_n = smbrw_pkg::ST_WADDR_NACK;
							smbrw_pkg::BN_CMD:   stat_n = smbrw_pkg::ST_CMD_NACK;
							default:             stat_n = smbrw_pkg::ST_RADDR_NACK;
						endcase
						tick_n  = '0;
						wait_n  = '0;
						phase_n = smbrw_pkg::PH_STOP_A;
					end else begin
						wait_n = wait_inc[smbrw_pkg::CNT_W-1:0];
					end
				end
				smbrw_pkg::PH_RX_HIGH: begin
					if (seg_last) begin
						tick_n  = '0;
						shift_n = {shift_q[6:0], sda_s1};
						if (bit_q == 4'd7) begin
							bit_n   = '0;
							phase_n = smbrw_pkg::PH_MACK_LOW;
						end else begin
							bit_n   = bit_q + 4'd1;
							phase_n = smbrw_pkg::PH_RX_LOW;
						end
					end else begin
						tick_n = tick_inc[smbrw_pkg::CNT_W-1:0];
					end
				end
				smbrw_pkg::PH_MACK_HIGH: begin
					if (seg_last) begin
						tick_n = '0;
						priority case (bnum_q)
							smbrw_pkg::BN_LOW: begin
								low_n   = shift_q;
								crc_n   = crc_upd;
								bnum_n  = smbrw_pkg::BN_HIGH;
								shift_n = '0;
								phase_n = smbrw_pkg::PH_RX_LOW;
							end
							smbrw_pkg::BN_HIGH: begin
								high_n  = shift_q;
								crc_n   = crc_upd;
								bnum_n  = smbrw_pkg::BN_PEC;
								shift_n = '0;
								phase_n = smbrw_pkg::PH_RX_LOW;
							end
							default: phase_n = smbrw_pkg::PH_STOP_A;
						endcase
					end else begin
						tick_n = tick_inc[smbrw_pkg::CNT_W-1:0];
					end
				end
				smbrw_pkg::PH_STOP_C: begin
					if (seg_last) begin
						tick_n  = '0;
						phase_n = smbrw_pkg::PH_IDLE;
						done_n  = 1'b1;
					end else begin
						tick_n = tick_inc[smbrw_pkg::CNT_W-1:0];
					end
				end
				default: phase_n = smbrw_pkg::PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= smbrw_pkg::PH_IDLE;
			bit_q   <= '0;
			bnum_q  <= smbrw_pkg::BN_WADDR;
			stat_q  <= smbrw_pkg::ST_OK;
			shift_q <= '0;
			low_q   <= '0;
			high_q  <= '0;
			crc_q   <= '0;
			haddr_q <= '0;
			hcmd_q  <= '0;
			tick_q  <= '0;
			wait_q  <= '0;
		end else begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			bnum_q  <= bnum_n;
			stat_q  <= stat_n;
			shift_q <= shift_n;
			low_q   <= low_n;
			high_q  <= high_n;
			crc_q   <= crc_n;
			haddr_q <= haddr_n;
			hcmd_q  <= hcmd_n;
			tick_q  <= tick_n;
			wait_q  <= wait_n;
		end
	end

	// ---------------------------------------------------------------
	// Pin levels, decoded from the phase this beat lands in.
	// The data bit on SDA is the shift register's top bit; the master
	// ACKs the low and high bytes and NACKs the PEC byte.
	// ---------------------------------------------------------------
	logic scl_n, sda_n;

	always_comb begin
		unique case (phase_n)
			smbrw_pkg::PH_PSTOP_A, smbrw_pkg::PH_STOP_A: begin
				scl_n = 1'b0;
				sda_n = 1'b0;
			end
			smbrw_pkg::PH_PSTOP_B, smbrw_pkg::PH_STOP_B, smbrw_pkg::PH_START_C: begin
				scl_n = 1'b1;
				sda_n = 1'b0;
			end
			smbrw_pkg::PH_START_A, smbrw_pkg::PH_ACK_LOW, smbrw_pkg::PH_RX_LOW: begin
				scl_n = 1'b0;
				sda_n = 1'b1;
			end
			smbrw_pkg::PH_TX_LOW: begin
				scl_n = 1'b0;
				sda_n = shift_n[7];
			end
			smbrw_pkg::PH_TX_HIGH: begin
				scl_n = 1'b1;
				sda_n = shift_n[7];
			end
			smbrw_pkg::PH_MACK_LOW: begin
				scl_n = 1'b0;
				sda_n = (bnum_n == smbrw_pkg::BN_PEC);
			end
			smbrw_pkg::PH_MACK_HIGH: begin
				scl_n = 1'b1;
				sda_n = (bnum_n == smbrw_pkg::BN_PEC);
			end
			default: begin
				scl_n = 1'b1;
				sda_n = 1'b1;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Result register s2: hold until taken, refill on every advance.
	// Word, PEC flag and status show only on the done beat.
	// ---------------------------------------------------------------
	logic        scl_s2, sda_s2, busy_s2, done_s2, pec_s2;
	logic [15:0] word_s2;
	logic [1:0]  stat_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s2 <= 1'b0;
		end else if (adv) begin
			out_vld_s2 <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scl_s2  <= scl_n;
			sda_s2  <= sda_n;
			busy_s2 <= (phase_n != smbrw_pkg::PH_IDLE);
			done_s2 <= done_n;
			if (!done_n) begin
				word_s2 <= '0;
				pec_s2  <= 1'b0;
				stat_s2 <= smbrw_pkg::ST_OK;
			end else if (stat_n == smbrw_pkg::ST_OK) begin
				word_s2 <= {high_n, low_n};
				pec_s2  <= (shift_n == crc_n);
				stat_s2 <= stat_n;
			end else begin
				word_s2 <= smbrw_pkg::NACK_WORD;
				pec_s2  <= 1'b0;
				stat_s2 <= stat_n;
			end
		end
	end

	assign rsp.valid       = out_vld_s2;
	assign rsp.scl_out     = scl_s2;
	assign rsp.sda_out     = sda_s2;
	assign rsp.busy_res    = busy_s2;
	assign rsp.done_res    = done_s2;
	assign rsp.read_word   = word_s2;
	assign rsp.pec_ok      = pec_s2;
	assign rsp.status_code = stat_s2;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`ASSERT_IMPLIES(a_stall_only_on_full, in_vld_s1 && !req.ready, out_vld_s2 && !rsp.ready, "input stalled without a held result")
	`ASSERT_IMPLIES(a_done_idle, out_vld_s2 && done_s2, !busy_s2 && scl_s2 && sda_s2, "done beat while bus still busy")
	`ASSERT_IMPLIES(a_nack_word, out_vld_s2 && done_s2 && stat_s2 != smbrw_pkg::ST_OK, word_s2 == smbrw_pkg::NACK_WORD && !pec_s2, "NACK result without error word")
	`ASSERT_ALWAYS(a_bit_range, bit_q < 4'd8, "bit index out of range")
	`ASSERT_NEXT(a_hold_state, !adv, $stable(phase_q) && $stable(tick_q), "sequencer moved without a beat")

endmodule
